// File: hw/rtl/wrwg_pkg.sv
package wrwg_pkg;

   // Width of sample indices and of every configuration register.
   localparam int INDEX_BITS = 24;
   // Bits of the ramp fraction below the binary point.
   localparam int FRAC_BITS = 16;
   // One division step per dividend bit: 2*d followed by the fraction bits.
   localparam int STEPS = INDEX_BITS + FRAC_BITS + 1;
   localparam int VALUE_BITS = FRAC_BITS + 1;
   localparam logic [VALUE_BITS-1:0] ONE_FIX = VALUE_BITS'(1) << FRAC_BITS;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELAY  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END    = 2'd3;

   // Data that travels down the divider chain with one word.
   typedef struct packed {
      logic                  active;
      logic [INDEX_BITS-1:0] rem_a;
      logic [INDEX_BITS-1:0] rem_b;
      logic [STEPS-1:0]      div_a;
      logic [STEPS-1:0]      div_b;
      logic [FRAC_BITS-1:0]  quo;
   } stage_type;

endpackage

// File: hw/rtl/wrwg_req_if.sv
interface wrwg_req_if;
   logic                           valid;
   logic                           ready;
   logic [wrwg_pkg::INDEX_BITS-1:0] sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink (input valid, input sample_index, output ready);
endinterface

// File: hw/rtl/wrwg_rsp_if.sv
interface wrwg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wrwg_pkg::VALUE_BITS-1:0] ramp_value;
   logic                           active;

   modport source (output valid, output ramp_value, output active, input ready);
   modport sink (input valid, input ramp_value, input active, output ready);
endinterface

// File: hw/rtl/wrwg_csr_if.sv
interface wrwg_csr_if;
   logic                               valid;
   logic                               ready;
   logic [wrwg_pkg::CSR_INDEX_BITS-1:0] index;
   logic [wrwg_pkg::INDEX_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/wrwg_cell.sv
module wrwg_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [wrwg_pkg::INDEX_BITS-1:0] period,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  wrwg_pkg::stage_type             up_word,
   output logic                            down_valid,
   input  logic                            down_ready,
   output wrwg_pkg::stage_type             down_word
);

   logic                            valid_ff;
   logic                            valid_in;
   wrwg_pkg::stage_type             word_ff;
   wrwg_pkg::stage_type             word_in;
   logic [wrwg_pkg::INDEX_BITS:0]   trial_a;
   logic [wrwg_pkg::INDEX_BITS:0]   trial_b;
   logic [wrwg_pkg::INDEX_BITS:0]   diff_a;
   logic [wrwg_pkg::INDEX_BITS:0]   diff_b;
   logic                            fit_a;
   logic                            fit_b;

   // The cell takes a word whenever it is empty or its own word moves on.
   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // One restoring division step on each lane: shift in the next dividend bit
   // and subtract the period when it fits. The remainder stays below the period.
   always_comb begin
      trial_a = {up_word.rem_a, up_word.div_a[wrwg_pkg::STEPS-1]};
      trial_b = {up_word.rem_b, up_word.div_b[wrwg_pkg::STEPS-1]};
      diff_a  = trial_a - {1'b0, period};
      diff_b  = trial_b - {1'b0, period};
      fit_a   = trial_a >= {1'b0, period};
      fit_b   = trial_b >= {1'b0, period};

      word_in        = up_word;
      word_in.rem_a  = fit_a ? diff_a[wrwg_pkg::INDEX_BITS-1:0]
                             : trial_a[wrwg_pkg::INDEX_BITS-1:0];
      word_in.rem_b  = fit_b ? diff_b[wrwg_pkg::INDEX_BITS-1:0]
                             : trial_b[wrwg_pkg::INDEX_BITS-1:0];
      word_in.div_a  = {up_word.div_a[wrwg_pkg::STEPS-2:0], 1'b0};
      word_in.div_b  = {up_word.div_b[wrwg_pkg::STEPS-2:0], 1'b0};
      word_in.quo    = {up_word.quo[wrwg_pkg::FRAC_BITS-2:0], fit_a};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule

// File: hw/rtl/windowed_ramp_wave_generator_unit.sv
// Windowed ramp wave generator. Each request word carries a sample index and
// yields one response word with the ramp value (65536 stands for 1.0) and an
// active flag, set when start_delay < sample_index <= end_index. The work is
// a chain of 41 division cells, one quotient bit per cell, that forms the
// remainders modulo the period and the 16-bit fraction together; a new word
// enters every cycle while the response side is ready, and results leave the
// last cell for the response port. Empty cells fill while the response side
// stalls, so the chain holds up to 41 words before it stops taking requests.
// Configuration writes take effect at once; the user must make them only while
// no word is in flight (not enforced); a period of zero acts as a period of one.
module windowed_ramp_wave_generator_unit (
   input  logic        clock,
   input  logic        reset,
   wrwg_req_if.sink    req,
   wrwg_rsp_if.source  rsp,
   wrwg_csr_if.sink    csr
);

   localparam int W = wrwg_pkg::INDEX_BITS;
   localparam int N = wrwg_pkg::STEPS;

   logic [W-1:0] period_ff;
   logic [W-1:0] phase_ff;
   logic [W-1:0] delay_ff;
   logic [W-1:0] end_ff;
   logic [W-1:0] period;
   logic [W-1:0] half;
   logic [W-1:0] offset;
   logic [W:0]   shifted;
   logic         in_window;

   wrwg_pkg::stage_type entry_word;
   wrwg_pkg::stage_type link_word  [0:N];
   logic                link_valid [0:N];
   logic                link_ready [0:N];
   wrwg_pkg::stage_type last_word;
   logic                rising;

   // Configuration registers; the port never stalls.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= W'(1);
         phase_ff  <= '0;
         delay_ff  <= '0;
         end_ff    <= '1;
      end else if (csr.valid) begin
         unique case (csr.index)
            wrwg_pkg::REG_PERIOD: period_ff <= csr.data;
            wrwg_pkg::REG_PHASE:  phase_ff  <= csr.data;
            wrwg_pkg::REG_DELAY:  delay_ff  <= csr.data;
            wrwg_pkg::REG_END:    end_ff    <= csr.data;
            default: ;
         endcase
      end
   end

   assign period = (period_ff == '0) ? W'(1) : period_ff;
   assign half   = period >> 1;

   // Entry word: window test, offset from the delay, and the two dividends.
   // Lane A divides 2*d with the fraction bits below it, lane B takes d+phase.
   always_comb begin
      in_window = (req.sample_index > delay_ff) && (req.sample_index <= end_ff);
      offset    = req.sample_index - delay_ff;
      shifted   = {1'b0, offset} + {1'b0, phase_ff};

      entry_word        = '0;
      entry_word.active = in_window;
      entry_word.div_a  = {offset, (wrwg_pkg::FRAC_BITS + 1)'(0)};
      entry_word.div_b  = N'(shifted);
   end

   assign link_word[0]  = entry_word;
   assign link_valid[0] = req.valid;
   assign req.ready     = link_ready[0];

   // Chain of division cells.
   for (genvar i = 0; i < N; i++) begin : g_cell
      wrwg_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .period     (period),
         .up_valid   (link_valid[i]),
         .up_ready   (link_ready[i]),
         .up_word    (link_word[i]),
         .down_valid (link_valid[i+1]),
         .down_ready (link_ready[i+1]),
         .down_word  (link_word[i+1])
      );
   end

   assign link_ready[N] = rsp.ready;
   assign last_word     = link_word[N];

   // Falling half when the phase-shifted position reaches half the period.
   assign rising = last_word.rem_b < half;

   assign rsp.valid      = link_valid[N];
   assign rsp.active     = last_word.active;
   assign rsp.ramp_value = !last_word.active ? '0 :
                           rising ? {1'b0, last_word.quo} :
                           wrwg_pkg::ONE_FIX - {1'b0, last_word.quo};

endmodule
